// ----- src/snpr_pkg.sv -----
package snpr_pkg;

	localparam int NUM_CODES   = 10;
	localparam int NUM_ALLELES = 4;
	localparam int OPCODE_W    = 2;
	localparam int GENO_W      = 4;
	localparam int SNP_W       = 2;
	localparam int COUNT_W     = 16;
	localparam int ALLELE_W    = 2;

	localparam logic [OPCODE_W-1:0] OP_TALLY  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_CLOSE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_RECODE = 2'd2;

	localparam logic [SNP_W-1:0] SNP_MISSING  = 2'd0;
	localparam logic [SNP_W-1:0] SNP_HOM_LO   = 2'd1;
	localparam logic [SNP_W-1:0] SNP_HET      = 2'd2;
	localparam logic [SNP_W-1:0] SNP_HOM_HI   = 2'd3;

	typedef logic [NUM_CODES-1:0] seen_t;
	typedef logic [NUM_CODES-1:0][SNP_W-1:0] code_map_t;

	typedef struct packed {
		logic      bad;
		code_map_t code_map;
	} decision_t;

	// Alleles of each pair code 1..10 (entry c-1), 0-based A,C,G,T.
	localparam logic [NUM_CODES-1:0][ALLELE_W-1:0] CODE_LO = {
		2'd3, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0
	};
	localparam logic [NUM_CODES-1:0][ALLELE_W-1:0] CODE_HI = {
		2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0
	};

	function automatic logic code_valid(input logic [GENO_W-1:0] code);
		return (code != '0) && (code <= GENO_W'(NUM_CODES));
	endfunction

endpackage

// ----- src/snpr_if.sv -----
interface snpr_in_if;
	import snpr_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [GENO_W-1:0]   geno_code;

	modport source (output valid, opcode, geno_code, input ready);
	modport sink (input valid, opcode, geno_code, output ready);
endinterface

interface snpr_out_if;
	import snpr_pkg::*;

	logic               valid;
	logic               ready;
	logic [SNP_W-1:0]   snp_code;
	logic               not_snp;
	logic [COUNT_W-1:0] rejected_columns;

	modport source (output valid, snp_code, not_snp, rejected_columns, input ready);
	modport sink (input valid, snp_code, not_snp, rejected_columns, output ready);
endinterface

// ----- src/snpr_decide.sv -----
module snpr_decide (
	input  snpr_pkg::seen_t     seen,
	output snpr_pkg::decision_t decision
);
	import snpr_pkg::*;

	logic [NUM_ALLELES-1:0] present;
	logic [NUM_ALLELES-1:0] lowest;
	logic [NUM_ALLELES-1:0] below;

	// Allele presence: a column is a SNP only with at most two alleles.
	always_comb begin
		present = '0;
		for (int c = 0; c < NUM_CODES; c++) begin
			if (seen[c]) begin
				present[CODE_LO[c]] = 1'b1;
				present[CODE_HI[c]] = 1'b1;
			end
		end
	end

	// One-hot of the lowest present allele; its hom maps to the first SNP code.
	always_comb begin
		below = '0;
		for (int a = 1; a < NUM_ALLELES; a++)
			below[a] = below[a-1] | present[a-1];
		lowest = present & ~below;
	end

	always_comb begin
		decision.bad = $countones(present) > 2;
		for (int c = 0; c < NUM_CODES; c++) begin
			if (!seen[c] || decision.bad)
				decision.code_map[c] = SNP_MISSING;
			else if (CODE_LO[c] != CODE_HI[c])
				decision.code_map[c] = SNP_HET;
			else if (lowest[CODE_LO[c]])
				decision.code_map[c] = SNP_HOM_LO;
			else
				decision.code_map[c] = SNP_HOM_HI;
		end
	end

endmodule

// ----- src/snp_genotype_recoder.sv -----
// SNP genotype recoder.
// geno_in carries (opcode, geno_code) transactions; snp_out carries
// (snp_code, not_snp, rejected_columns). Both use valid/ready.
// Opcode tally marks a pair code as seen in the open column and gives no
// result. Close decides the column from the seen codes, latches the map and
// verdict, clears the seen codes and gives one result with snp_code 0.
// Recode gives the mapped code of the latched column (0 when rejected).
// Opcode 3 and out-of-range codes are ignored or read as missing.
// A result passes through the input register, then the result register,
// where it is held until the receiver takes it.
// Throughput: one transaction per cycle unless a result stall refuses input,
// set by the state update between the two registers.
// Reset clears the seen codes, map, verdict and reject count, and empties
// both registers. When the receiver stalls the result register holds; a
// transaction that gives no result still retires, and input is refused
// only while a result-giving transaction waits behind a full result register.
module snp_genotype_recoder (
	input  logic             clk,
	input  logic             arst_n,
	snpr_in_if.sink          geno_in,
	snpr_out_if.source       snp_out
);
	import snpr_pkg::*;

	logic                valid_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [GENO_W-1:0]   code_s1;

	logic                valid_s2;
	logic [SNP_W-1:0]    snp_code_s2;
	logic                not_snp_s2;
	logic [COUNT_W-1:0]  count_s2;

	seen_t               seen_q;
	code_map_t           map_q;
	logic                rejected_q;
	logic [COUNT_W-1:0]  count_q;

	decision_t           decision;
	logic                has_result;
	logic                advance;
	logic                is_close;
	logic                code_ok;
	logic [GENO_W-1:0]   code_idx;
	logic [COUNT_W-1:0]  count_next;

	snpr_decide u_decide (
		.seen     (seen_q),
		.decision (decision)
	);

	assign is_close   = opcode_s1 == OP_CLOSE;
	assign has_result = is_close || (opcode_s1 == OP_RECODE);
	assign advance    = valid_s1 && (!has_result || !valid_s2 || snp_out.ready);
	assign geno_in.ready = !valid_s1 || advance;

	assign code_ok  = code_valid(code_s1);
	assign code_idx = code_s1 - GENO_W'(1);
	assign count_next = (decision.bad && count_q != '1) ? count_q + COUNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (geno_in.ready) begin
			valid_s1 <= geno_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (geno_in.valid && geno_in.ready) begin
			opcode_s1 <= geno_in.opcode;
			code_s1   <= geno_in.geno_code;
		end
	end

	// Column state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			map_q      <= '0;
			rejected_q <= 1'b0;
			count_q    <= '0;
		end else if (advance) begin
			case (opcode_s1)
				OP_TALLY: begin
					if (code_ok)
						seen_q[code_idx] <= 1'b1;
				end
				OP_CLOSE: begin
					seen_q     <= '0;
					map_q      <= decision.code_map;
					rejected_q <= decision.bad;
					count_q    <= count_next;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && has_result) begin
			valid_s2 <= 1'b1;
		end else if (snp_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			if (is_close) begin
				snp_code_s2 <= SNP_MISSING;
				not_snp_s2  <= decision.bad;
				count_s2    <= count_next;
			end else begin
				snp_code_s2 <= code_ok ? map_q[code_idx] : SNP_MISSING;
				not_snp_s2  <= rejected_q;
				count_s2    <= count_q;
			end
		end
	end

	assign snp_out.valid            = valid_s2;
	assign snp_out.snp_code         = snp_code_s2;
	assign snp_out.not_snp          = not_snp_s2;
	assign snp_out.rejected_columns = count_s2;

	a_close_clears_seen: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_close |=> seen_q == '0)
		else $error("seen codes not cleared after close");

	a_rejected_map_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rejected_q |-> map_q == '0)
		else $error("rejected column has a non-zero map");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance && is_close) |-> $stable(count_q))
		else $error("reject count changed outside a close");

	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1 && has_result))
		else $error("result appeared without a result-giving transaction");

endmodule
